@@ rtl/core/hsp_pkg.sv @@
package hsp_pkg;

    localparam int COORD_W  = 32;   // signed Q16.16 coordinates
    localparam int PARAM_W  = 17;   // unsigned Q0.16 parameter, 1.0 = 2^16
    localparam int TAG_W    = 2;
    localparam int WEIGHT_W = 31;   // basis weight in Q0.30, 0..2^30
    localparam int T2_W     = 33;   // t^2 in Q0.32
    localparam int T3_W     = 49;   // t^3 in Q0.48
    localparam int WIDE_W   = 51;   // headroom for weight sums in Q0.48
    localparam int PROD_W   = 64;   // Q16.16 x Q0.30 product and its sums

    localparam logic [PARAM_W-1:0] ONE_Q16  = PARAM_W'(1) << 16;
    localparam logic [WIDE_W-1:0]  ONE_Q48  = WIDE_W'(1) << 48;
    localparam logic [WIDE_W-1:0]  HALF_W30 = WIDE_W'(1) << 17;

    typedef logic [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        weight_t w00;
        weight_t w10;
        weight_t w01;
        weight_t w11;   // t^2 - t^3, tangent_b term is added with this
    } weights_t;

    // Q0.48 -> Q0.30, half rounds up; input is never above 2^48
    function automatic weight_t round_weight(input logic [WIDE_W-1:0] w48);
        logic [WIDE_W-1:0] s;
        s = w48 + HALF_W30;
        return s[48:18];
    endfunction

endpackage

@@ rtl/core/hsp_basis.sv @@
module hsp_basis (
    input  logic                         clk,
    input  logic [2:0]                   load,
    input  logic [hsp_pkg::PARAM_W-1:0]  curve_param,
    output hsp_pkg::weights_t            weights
);
    import hsp_pkg::*;

    logic [PARAM_W-1:0] t_clamp;
    logic [T2_W-1:0]    t2_next;
    logic [T3_W-1:0]    t3_next;
    logic [WIDE_W-1:0]  t3e, t2s, t1s;
    weights_t           weights_next;

    logic [PARAM_W-1:0] t1_reg, t1b_reg;
    logic [T2_W-1:0]    t2_reg, t2b_reg;
    logic [T3_W-1:0]    t3_reg;
    weights_t           weights_reg;

    // stage 1: clamp t to 1.0, square it
    assign t_clamp = (curve_param > ONE_Q16) ? ONE_Q16 : curve_param;
    assign t2_next = T2_W'(T2_W'(t_clamp) * T2_W'(t_clamp));

    // stage 2: cube
    assign t3_next = T3_W'(T3_W'(t2_reg) * T3_W'(t1_reg));

    // stage 3: four weights in Q0.48, then rounded to Q0.30
    assign t3e = WIDE_W'(t3_reg);
    assign t2s = WIDE_W'({t2b_reg, 16'b0});
    assign t1s = WIDE_W'({t1b_reg, 32'b0});

    always_comb
    begin
        weights_next.w00 = round_weight((t3e << 1) + ONE_Q48 - (t2s << 1) - t2s);
        weights_next.w10 = round_weight(t3e + t1s - (t2s << 1));
        weights_next.w01 = round_weight((t2s << 1) + t2s - (t3e << 1));
        weights_next.w11 = round_weight(t2s - t3e);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            t1_reg <= t_clamp;
            t2_reg <= t2_next;
        end
        if (load[1])
        begin
            t1b_reg <= t1_reg;
            t2b_reg <= t2_reg;
            t3_reg  <= t3_next;
        end
        if (load[2])
        begin
            weights_reg <= weights_next;
        end
    end

    assign weights = weights_reg;

endmodule

@@ rtl/core/hermite_spline_point.sv @@
// Cubic Hermite curve evaluator, one coordinate per beat.
// Input channel (in_valid / in_stall): one axis of the start point, start
// tangent, end tangent and end point (signed Q16.16), the curve parameter
// (Q0.16, values above 1.0 are taken as 1.0) and an axis tag.
// Output channel (out_valid / out_stall): point_a*h00 + tangent_a*h10 +
// point_b*h01 - tangent_b*h11 rounded to Q16.16, clamped to the signed
// 32 bit range with saturated flagging a clamp, and the tag copied through.
// Throughput: one beat per cycle while out_stall is low. Seven register stages: clamp
// and t^2, t^3, basis weights, four 32x32 products, pairwise sums, final
// sum with rounding, saturation into the output register. Each stage
// carries a valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles are squeezed out. When the receiver stalls, the
// output holds; in_stall rises only once every stage is full.
// Reset clears all valid bits; data registers are not reset.
module hermite_spline_point (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [hsp_pkg::COORD_W-1:0] point_a,
    input  logic signed [hsp_pkg::COORD_W-1:0] tangent_a,
    input  logic signed [hsp_pkg::COORD_W-1:0] tangent_b,
    input  logic signed [hsp_pkg::COORD_W-1:0] point_b,
    input  logic        [hsp_pkg::PARAM_W-1:0] curve_param,
    input  logic        [hsp_pkg::TAG_W-1:0]   axis_tag,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [hsp_pkg::COORD_W-1:0] curve_coord,
    output logic        [hsp_pkg::TAG_W-1:0]   axis_tag_out,
    output logic                               saturated
);
    import hsp_pkg::*;

    localparam int LAST = 7;

    localparam logic signed [PROD_W-1:0] HALF_Q16 = PROD_W'(1) << 29;
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // ---- pipeline control ----
    logic [LAST:1] vld_reg;
    logic [LAST:1] rdy;       // stage may take a new beat this cycle
    logic [LAST:1] src_vld;   // valid of the beat offered to each stage
    logic [LAST:1] load;

    always_comb
    begin
        rdy[LAST] = !vld_reg[LAST] || !out_stall;
        for (int i = LAST - 1; i >= 1; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign src_vld  = {vld_reg[LAST-1:1], in_valid};
    assign load     = rdy & src_vld;
    assign in_stall = !rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= LAST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= src_vld[i];
                end
            end
        end
    end

    // ---- stages 1..3: basis weights, coordinates ride alongside ----
    weights_t weights;

    hsp_basis u_basis (
        .clk         (clk),
        .load        (load[3:1]),
        .curve_param (curve_param),
        .weights     (weights)
    );

    logic signed [COORD_W-1:0] pa_reg [1:3];
    logic signed [COORD_W-1:0] ta_reg [1:3];
    logic signed [COORD_W-1:0] tb_reg [1:3];
    logic signed [COORD_W-1:0] pb_reg [1:3];
    logic        [TAG_W-1:0]   tag_reg [1:6];

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            pa_reg[1]  <= point_a;
            ta_reg[1]  <= tangent_a;
            tb_reg[1]  <= tangent_b;
            pb_reg[1]  <= point_b;
            tag_reg[1] <= axis_tag;
        end
        for (int i = 2; i <= 3; i++)
        begin
            if (load[i])
            begin
                pa_reg[i] <= pa_reg[i-1];
                ta_reg[i] <= ta_reg[i-1];
                tb_reg[i] <= tb_reg[i-1];
                pb_reg[i] <= pb_reg[i-1];
            end
        end
        for (int i = 2; i <= 6; i++)
        begin
            if (load[i])
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // ---- stage 4: products, Q16.16 x Q0.30 = Q16.46 ----
    // operands are sign-extended to the full product width first
    logic signed [PROD_W-1:0] prod_next [0:3];
    logic signed [PROD_W-1:0] prod_reg  [0:3];

    assign prod_next[0] = PROD_W'(pa_reg[3]) * PROD_W'($signed({1'b0, weights.w00}));
    assign prod_next[1] = PROD_W'(ta_reg[3]) * PROD_W'($signed({1'b0, weights.w10}));
    assign prod_next[2] = PROD_W'(pb_reg[3]) * PROD_W'($signed({1'b0, weights.w01}));
    assign prod_next[3] = PROD_W'(tb_reg[3]) * PROD_W'($signed({1'b0, weights.w11}));

    // ---- stages 5, 6: sum tree, then round (half toward +inf) ----
    logic signed [PROD_W-1:0] sum01_reg, sum23_reg, acc_reg;
    logic signed [PROD_W-1:0] acc_next;

    assign acc_next = sum01_reg + sum23_reg + HALF_Q16;

    // ---- stage 7: floor shift by 30, clamp to 32 bits ----
    // acc[63:30] fits in 32 bits exactly when the top three bits agree
    logic                      ovf_next;
    logic signed [COORD_W-1:0] coord_next;
    logic signed [COORD_W-1:0] coord_reg;
    logic                      sat_reg;

    assign ovf_next   = (acc_reg[63:61] != 3'b000) && (acc_reg[63:61] != 3'b111);
    assign coord_next = !ovf_next   ? acc_reg[61:30] :
                        acc_reg[63] ? COORD_MIN : COORD_MAX;

    logic [TAG_W-1:0] tag_out_reg;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (load[5])
        begin
            sum01_reg <= prod_reg[0] + prod_reg[1];
            sum23_reg <= prod_reg[2] + prod_reg[3];
        end
        if (load[6])
        begin
            acc_reg <= acc_next;
        end
        if (load[7])
        begin
            coord_reg   <= coord_next;
            sat_reg     <= ovf_next;
            tag_out_reg <= tag_reg[6];
        end
    end

    assign out_valid    = vld_reg[LAST];
    assign curve_coord  = coord_reg;
    assign axis_tag_out = tag_out_reg;
    assign saturated    = sat_reg;

    // ---- checks ----
    // input backs up only when the output beat is held
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a held output beat");

    // a clamped beat carries one of the two bounds
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (curve_coord == COORD_MAX || curve_coord == COORD_MIN))
        else $error("saturated set on an unclamped value");

    // no output beat appears without one in the stage before it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!vld_reg[LAST-1] && (!out_valid || !out_stall)) |=> !out_valid)
        else $error("output beat from an empty pipeline");

endmodule
